/* hdl/length_prefixed_frame_parser_defines.svh */
// Assertion helpers for the checker file lpfp_checker.sv.
`ifndef LENGTH_PREFIXED_FRAME_PARSER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define LPFP_ASSERT_IMP(label, c, r, ante, cons, msg) \
  label: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define LPFP_ASSERT_NXT(label, c, r, ante, cons, msg) \
  label: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
    else $error(msg);

// Holds on the cycle after reset is sampled low.
`define LPFP_ASSERT_RST(label, c, r, cons, msg) \
  label: assert property (@(posedge c) (!r) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lpfp_pkg.sv */
package lpfp_pkg;

  localparam int HDR_BYTES    = 21;
  localparam int MAX_LEN_W    = 21;
  localparam int PLEN_W       = 20;
  localparam int IDX_W        = 5;
  localparam logic [IDX_W-1:0] LEN_LAST_IDX = IDX_W'(3);
  localparam logic [IDX_W-1:0] HDR_LAST_IDX = IDX_W'(HDR_BYTES - 1);
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = MAX_LEN_W'(8192);

  typedef enum logic [1:0] {
    KIND_HEADER    = 2'd0,
    KIND_PAYLOAD   = 2'd1,
    KIND_LEN_BAD   = 2'd2,
    KIND_LEN_SHORT = 2'd3
  } kind_t;

  typedef enum logic {
    PH_HEADER  = 1'b0,
    PH_PAYLOAD = 1'b1
  } phase_t;

  typedef struct packed {
    kind_t              kind;
    logic [15:0]        main_id;
    logic [15:0]        sub_id;
    logic [31:0]        sequence_number;
    logic [7:0]         compress_flag;
    logic signed [63:0] reserve_word;
    logic [PLEN_W-1:0]  payload_length;
    logic [7:0]         out_byte;
    logic               last;
  } res_t;

endpackage

/* hdl/lpfp_if.sv */
interface lpfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface lpfp_result_if;
  logic                          valid;
  logic                          ready;
  lpfp_pkg::kind_t               kind;
  logic [15:0]                   main_id;
  logic [15:0]                   sub_id;
  logic [31:0]                   sequence_number;
  logic [7:0]                    compress_flag;
  logic signed [63:0]            reserve_word;
  logic [lpfp_pkg::PLEN_W-1:0]   payload_length;
  logic [7:0]                    out_byte;
  logic                          last;

  modport source (output valid, output kind, output main_id, output sub_id,
                  output sequence_number, output compress_flag, output reserve_word,
                  output payload_length, output out_byte, output last, input ready);
  modport sink   (input valid, input kind, input main_id, input sub_id,
                  input sequence_number, input compress_flag, input reserve_word,
                  input payload_length, input out_byte, input last, output ready);
endinterface

/* hdl/length_prefixed_frame_parser.sv */
// Channel   Dir  Transfer                 Payload
// in_ch     in   one stream byte          in_byte
// out_ch    out  one header/payload/err   kind, header fields, payload_length,
//                                         out_byte, last
// cfg_*     in   register write           max_frame_length (21 bits)
//
// One byte per cycle while in_ch.ready is high; each result is registered into
// the output register or into the skid entry.
// Reset (rst_n, synchronous, low): parser back to header start, output empty,
// max_frame_length = 8192.
// A two-entry output (register plus skid) absorbs a stall; in_ch.ready drops
// only when both entries hold results.
module length_prefixed_frame_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  lpfp_byte_if.sink                        in_ch,
  lpfp_result_if.source                    out_ch,
  input  logic                             cfg_wr_en,
  input  logic [lpfp_pkg::MAX_LEN_W-1:0]   cfg_wr_data
);

  lpfp_pkg::phase_t                  phase_r, phase_nxt;
  logic [lpfp_pkg::IDX_W-1:0]        hdr_idx_r, hdr_idx_nxt;
  logic [31:0]                       len_r, len_nxt;
  logic [15:0]                       main_r, main_nxt;
  logic [15:0]                       sub_r, sub_nxt;
  logic [31:0]                       seq_r, seq_nxt;
  logic [7:0]                        flag_r, flag_nxt;
  logic signed [63:0]                rsv_r, rsv_nxt;
  logic [lpfp_pkg::MAX_LEN_W-1:0]    left_r, left_nxt;
  logic [lpfp_pkg::MAX_LEN_W-1:0]    max_len_r;

  logic [7:0]                        b;
  logic                              in_acc;
  logic [2:0]                        rsv_sel;
  logic                              at_len, at_end, len_bad, len_short;
  logic [lpfp_pkg::MAX_LEN_W-1:0]    plen, left_dec;

  logic                              res_vld;
  lpfp_pkg::res_t                    res;

  logic                              out_vld_r, out_vld_nxt;
  logic                              skid_vld_r, skid_vld_nxt;
  lpfp_pkg::res_t                    out_r, out_nxt;
  lpfp_pkg::res_t                    skid_r, skid_nxt;
  logic                              out_pop;

  assign b           = in_ch.in_byte;
  assign in_ch.ready = !skid_vld_r;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // header field capture
  assign rsv_sel = 3'(hdr_idx_r - lpfp_pkg::IDX_W'(13));

  always_comb begin
    len_nxt  = len_r;
    main_nxt = main_r;
    sub_nxt  = sub_r;
    seq_nxt  = seq_r;
    flag_nxt = flag_r;
    rsv_nxt  = rsv_r;
    if (phase_r == lpfp_pkg::PH_HEADER) begin
      if (hdr_idx_r < lpfp_pkg::IDX_W'(4)) begin
        len_nxt[{hdr_idx_r[1:0], 3'b000} +: 8] = b;
      end else if (hdr_idx_r < lpfp_pkg::IDX_W'(6)) begin
        main_nxt[{hdr_idx_r[0], 3'b000} +: 8] = b;
      end else if (hdr_idx_r < lpfp_pkg::IDX_W'(8)) begin
        sub_nxt[{hdr_idx_r[0], 3'b000} +: 8] = b;
      end else if (hdr_idx_r < lpfp_pkg::IDX_W'(12)) begin
        seq_nxt[{hdr_idx_r[1:0], 3'b000} +: 8] = b;
      end else if (hdr_idx_r == lpfp_pkg::IDX_W'(12)) begin
        flag_nxt = b;
      end else if (hdr_idx_r <= lpfp_pkg::HDR_LAST_IDX) begin
        rsv_nxt[{rsv_sel, 3'b000} +: 8] = b;
      end
    end
  end

  assign at_len    = (hdr_idx_r == lpfp_pkg::LEN_LAST_IDX);
  assign at_end    = (hdr_idx_r == lpfp_pkg::HDR_LAST_IDX);
  assign len_bad   = (len_nxt == 32'd0) ||
                     (len_nxt >= {{(32 - lpfp_pkg::MAX_LEN_W){1'b0}}, max_len_r});
  assign len_short = (len_nxt < 32'(lpfp_pkg::HDR_BYTES));
  assign plen      = len_nxt[lpfp_pkg::MAX_LEN_W-1:0] -
                     lpfp_pkg::MAX_LEN_W'(lpfp_pkg::HDR_BYTES);
  assign left_dec  = left_r - lpfp_pkg::MAX_LEN_W'(1);

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    hdr_idx_nxt = hdr_idx_r;
    left_nxt    = left_r;
    unique case (phase_r)
      lpfp_pkg::PH_PAYLOAD: begin
        left_nxt = left_dec;
        if (left_dec == '0) phase_nxt = lpfp_pkg::PH_HEADER;
      end
      lpfp_pkg::PH_HEADER: begin
        priority if (at_len && (len_bad || len_short)) begin
          hdr_idx_nxt = '0;
        end else if (at_end) begin
          hdr_idx_nxt = '0;
          left_nxt    = plen;
          if (plen != '0) phase_nxt = lpfp_pkg::PH_PAYLOAD;
        end else begin
          hdr_idx_nxt = hdr_idx_r + lpfp_pkg::IDX_W'(1);
        end
      end
    endcase
  end

  // result
  always_comb begin
    res_vld = 1'b0;
    res     = '0;
    unique case (phase_r)
      lpfp_pkg::PH_PAYLOAD: begin
        res_vld             = 1'b1;
        res.kind            = lpfp_pkg::KIND_PAYLOAD;
        res.main_id         = main_r;
        res.sub_id          = sub_r;
        res.sequence_number = seq_r;
        res.compress_flag   = flag_r;
        res.reserve_word    = rsv_r;
        res.payload_length  = len_r[lpfp_pkg::PLEN_W-1:0] -
                              lpfp_pkg::PLEN_W'(lpfp_pkg::HDR_BYTES);
        res.out_byte        = b;
        res.last            = (left_dec == '0);
      end
      lpfp_pkg::PH_HEADER: begin
        priority if (at_len && len_bad) begin
          res_vld  = 1'b1;
          res.kind = lpfp_pkg::KIND_LEN_BAD;
          res.last = 1'b1;
        end else if (at_len && len_short) begin
          res_vld  = 1'b1;
          res.kind = lpfp_pkg::KIND_LEN_SHORT;
          res.last = 1'b1;
        end else if (at_end) begin
          res_vld             = 1'b1;
          res.kind            = lpfp_pkg::KIND_HEADER;
          res.main_id         = main_nxt;
          res.sub_id          = sub_nxt;
          res.sequence_number = seq_nxt;
          res.compress_flag   = flag_nxt;
          res.reserve_word    = rsv_nxt;
          res.payload_length  = plen[lpfp_pkg::PLEN_W-1:0];
          res.last            = (plen == '0);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= lpfp_pkg::PH_HEADER;
      hdr_idx_r <= '0;
    end else if (in_acc) begin
      phase_r   <= phase_nxt;
      hdr_idx_r <= hdr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      len_r  <= len_nxt;
      main_r <= main_nxt;
      sub_r  <= sub_nxt;
      seq_r  <= seq_nxt;
      flag_r <= flag_nxt;
      rsv_r  <= rsv_nxt;
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= lpfp_pkg::MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  // output register plus skid entry
  assign out_pop = !out_vld_r || out_ch.ready;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    skid_vld_nxt = skid_vld_r;
    skid_nxt     = skid_r;
    if (out_pop) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_nxt      = skid_r;
        skid_vld_nxt = in_acc && res_vld;
        skid_nxt     = res;
      end else begin
        out_vld_nxt = in_acc && res_vld;
        out_nxt     = res;
      end
    end else if (in_acc && res_vld) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.kind            = out_r.kind;
  assign out_ch.main_id         = out_r.main_id;
  assign out_ch.sub_id          = out_r.sub_id;
  assign out_ch.sequence_number = out_r.sequence_number;
  assign out_ch.compress_flag   = out_r.compress_flag;
  assign out_ch.reserve_word    = out_r.reserve_word;
  assign out_ch.payload_length  = out_r.payload_length;
  assign out_ch.out_byte        = out_r.out_byte;
  assign out_ch.last            = out_r.last;

endmodule

/* hdl/lpfp_checker.sv */
`include "length_prefixed_frame_parser_defines.svh"

module lpfp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    kind,
  input logic [15:0]                   main_id,
  input logic [lpfp_pkg::PLEN_W-1:0]   payload_length,
  input logic [7:0]                    out_byte,
  input logic                          last
);

  `LPFP_ASSERT_RST(a_reset_empty, clk, rst_n, !out_valid && in_ready, "output not empty after reset")

  `LPFP_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(kind) && $stable(main_id) && $stable(payload_length) && $stable(out_byte) && $stable(last), "stalled result changed")

  `LPFP_ASSERT_IMP(a_err_clean, clk, rst_n, out_valid && (kind == lpfp_pkg::KIND_LEN_BAD || kind == lpfp_pkg::KIND_LEN_SHORT), last && main_id == 16'd0 && payload_length == '0 && out_byte == 8'd0, "error transfer not terminal or not cleared")

  `LPFP_ASSERT_IMP(a_byte_only_payload, clk, rst_n, out_valid && kind != lpfp_pkg::KIND_PAYLOAD, out_byte == 8'd0, "byte on a non-payload transfer")

endmodule

bind length_prefixed_frame_parser lpfp_checker u_lpfp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .kind           (out_ch.kind),
  .main_id        (out_ch.main_id),
  .payload_length (out_ch.payload_length),
  .out_byte       (out_ch.out_byte),
  .last           (out_ch.last)
);

/* verif/frame_result_monitor.sv */
module frame_result_monitor (
  input  logic                           clk,
  input  logic                           rst_n,
  lpfp_byte_if                           in_ch,
  lpfp_result_if                         out_ch,
  input  logic                           cfg_wr_en,
  input  logic [lpfp_pkg::MAX_LEN_W-1:0] cfg_wr_data,
  output int                             fail_count,
  output int                             pending,
  output int                             n_headers,
  output int                             n_payload,
  output int                             n_errors
);

  localparam int PRINT_CAP = 40;

  lpfp_pkg::phase_t               ph;
  logic [lpfp_pkg::IDX_W-1:0]     hdr_idx;
  logic [31:0]                    frame_len;
  logic [15:0]                    main_q;
  logic [15:0]                    sub_q;
  logic [31:0]                    seq_q;
  logic [7:0]                     flag_q;
  logic [63:0]                    resv_q;
  logic [lpfp_pkg::MAX_LEN_W-1:0] bytes_left;
  logic [lpfp_pkg::MAX_LEN_W-1:0] max_len;
  lpfp_pkg::res_t                 expected_q[$];

  task automatic flag_mismatch(input string msg);
    if (fail_count < PRINT_CAP) $display("mismatch: %s", msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic lpfp_pkg::res_t frame_result(input lpfp_pkg::kind_t k,
                                                  input logic [7:0] b, input logic lst);
    lpfp_pkg::res_t r;
    r.kind            = k;
    r.main_id         = main_q;
    r.sub_id          = sub_q;
    r.sequence_number = seq_q;
    r.compress_flag   = flag_q;
    r.reserve_word    = resv_q;
    r.payload_length  = lpfp_pkg::PLEN_W'(frame_len - 32'(lpfp_pkg::HDR_BYTES));
    r.out_byte        = b;
    r.last            = lst;
    return r;
  endfunction

  function automatic lpfp_pkg::res_t length_error(input lpfp_pkg::kind_t k);
    lpfp_pkg::res_t r;
    r      = '0;
    r.kind = k;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    int i;
    i = int'(hdr_idx);
    if (ph == lpfp_pkg::PH_PAYLOAD) begin
      bytes_left = bytes_left - lpfp_pkg::MAX_LEN_W'(1);
      expected_q.push_back(frame_result(lpfp_pkg::KIND_PAYLOAD, b, bytes_left == '0));
      if (bytes_left == '0) begin
        ph      = lpfp_pkg::PH_HEADER;
        hdr_idx = '0;
      end
    end else begin
      if (i < 4) frame_len[i*8 +: 8] = b;
      else if (i < 6) main_q[(i-4)*8 +: 8] = b;
      else if (i < 8) sub_q[(i-6)*8 +: 8] = b;
      else if (i < 12) seq_q[(i-8)*8 +: 8] = b;
      else if (i == 12) flag_q = b;
      else resv_q[(i-13)*8 +: 8] = b;

      if (i == int'(lpfp_pkg::LEN_LAST_IDX) &&
          (frame_len == '0 || frame_len >= 32'(max_len))) begin
        expected_q.push_back(length_error(lpfp_pkg::KIND_LEN_BAD));
        hdr_idx = '0;
      end else if (i == int'(lpfp_pkg::LEN_LAST_IDX) &&
                   frame_len < 32'(lpfp_pkg::HDR_BYTES)) begin
        expected_q.push_back(length_error(lpfp_pkg::KIND_LEN_SHORT));
        hdr_idx = '0;
      end else if (i == int'(lpfp_pkg::HDR_LAST_IDX)) begin
        bytes_left = lpfp_pkg::MAX_LEN_W'(frame_len - 32'(lpfp_pkg::HDR_BYTES));
        expected_q.push_back(frame_result(lpfp_pkg::KIND_HEADER, 8'h00, bytes_left == '0));
        ph      = (bytes_left == '0) ? lpfp_pkg::PH_HEADER : lpfp_pkg::PH_PAYLOAD;
        hdr_idx = '0;
      end else begin
        hdr_idx = hdr_idx + lpfp_pkg::IDX_W'(1);
      end
    end
  endtask

  always @(posedge clk) begin
    lpfp_pkg::res_t want;
    if (!rst_n) begin
      ph         = lpfp_pkg::PH_HEADER;
      hdr_idx    = '0;
      frame_len  = '0;
      main_q     = '0;
      sub_q      = '0;
      seq_q      = '0;
      flag_q     = '0;
      resv_q     = '0;
      bytes_left = '0;
      max_len    = lpfp_pkg::MAX_LEN_RESET;
      expected_q.delete();
    end else begin
      if (cfg_wr_en) max_len = cfg_wr_data;
      if (in_ch.valid && in_ch.ready) deframe_byte(in_ch.in_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          flag_mismatch("result transfer with nothing expected");
        end else begin
          want = expected_q.pop_front();
          compare_field("kind", 64'(out_ch.kind), 64'(want.kind));
          compare_field("main_id", 64'(out_ch.main_id), 64'(want.main_id));
          compare_field("sub_id", 64'(out_ch.sub_id), 64'(want.sub_id));
          compare_field("sequence_number", 64'(out_ch.sequence_number),
                        64'(want.sequence_number));
          compare_field("compress_flag", 64'(out_ch.compress_flag),
                        64'(want.compress_flag));
          compare_field("reserve_word", 64'(out_ch.reserve_word), 64'(want.reserve_word));
          compare_field("payload_length", 64'(out_ch.payload_length),
                        64'(want.payload_length));
          compare_field("out_byte", 64'(out_ch.out_byte), 64'(want.out_byte));
          compare_field("last", 64'(out_ch.last), 64'(want.last));
          unique case (want.kind)
            lpfp_pkg::KIND_HEADER:  n_headers++;
            lpfp_pkg::KIND_PAYLOAD: n_payload++;
            default:                n_errors++;
          endcase
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

/* verif/testbench.sv */
module testbench;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int SEG_BYTES    = 300;
  localparam int RANDOM_FILL  = -1;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_wr_en;
  logic [lpfp_pkg::MAX_LEN_W-1:0] cfg_wr_data;

  lpfp_byte_if   in_if ();
  lpfp_result_if out_if ();

  int tx_idle_pct;
  int rx_idle_pct;
  int fail_count;
  int pending;
  int n_headers;
  int n_payload;
  int n_errors;
  int bytes_sent;
  int cycle_count;
  int max_now;
  int n_settings;
  int hold_left;
  bit hold_trigger;
  bit hold_seen;

  length_prefixed_frame_parser uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  frame_result_monitor mon (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .n_headers   (n_headers),
    .n_payload   (n_payload),
    .n_errors    (n_errors)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off when triggered
  always @(negedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen = hold_trigger;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic put_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic put_length(input logic [31:0] len);
    for (int k = 0; k < 4; k++) put_byte(len[k*8 +: 8]);
  endtask

  // fill < 0: random header and payload bytes, else that byte everywhere after the length field
  task automatic send_frame(input logic [31:0] len, input int fill);
    put_length(len);
    for (int k = 0; k < int'(len) - 4; k++)
      put_byte(fill < 0 ? 8'($urandom) : 8'(fill));
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_max_length(input int v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lpfp_pkg::MAX_LEN_W'(v);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    max_now = v;
    n_settings++;
  endtask

  task automatic random_traffic(input int n_bytes);
    int          stop;
    int          hi;
    logic [31:0] len;
    stop = bytes_sent + n_bytes;
    while (bytes_sent < stop) begin
      hi = max_now - 1;
      if (hi > lpfp_pkg::HDR_BYTES + 40) hi = lpfp_pkg::HDR_BYTES + 40;
      if (hi >= lpfp_pkg::HDR_BYTES && $urandom_range(99) < 80) begin
        if ($urandom_range(19) == 0 && max_now - 1 <= lpfp_pkg::HDR_BYTES + 400)
          len = 32'(max_now - 1);
        else
          len = $urandom_range(hi, lpfp_pkg::HDR_BYTES);
        send_frame(len, RANDOM_FILL);
      end else begin
        case ($urandom_range(3))
          0:       len = 32'd0;
          1:       len = $urandom_range(lpfp_pkg::HDR_BYTES - 1, 1);
          2:       len = 32'(max_now) + $urandom_range(500);
          default: len = $urandom | 32'h8000_0000;
        endcase
        put_length(len);
      end
    end
  endtask

  initial begin
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'h00;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    rst_n         = 1'b0;
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    max_now       = int'(lpfp_pkg::MAX_LEN_RESET);
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // length checks at the reset maximum
    put_length(32'd0);
    put_length(32'd1);
    put_length(32'(lpfp_pkg::HDR_BYTES - 1));
    put_length(32'(lpfp_pkg::MAX_LEN_RESET));
    put_length(32'hFFFF_FFFF);
    send_frame(32'(lpfp_pkg::HDR_BYTES), 255);
    send_frame(32'(lpfp_pkg::HDR_BYTES + 2), 0);
    // smallest useful maximum admits only an empty frame
    set_max_length(lpfp_pkg::HDR_BYTES + 1);
    send_frame(32'(lpfp_pkg::HDR_BYTES), RANDOM_FILL);
    put_length(32'(lpfp_pkg::HDR_BYTES + 1));
    // oversize wins over undersize
    set_max_length(10);
    put_length(32'd15);
    set_max_length(0);
    put_length(32'(lpfp_pkg::HDR_BYTES));

    tx_idle_pct = 23;
    rx_idle_pct = 82;
    set_max_length(64);
    random_traffic(SEG_BYTES);
    set_max_length(1048576);
    random_traffic(SEG_BYTES);

    tx_idle_pct = 82;
    rx_idle_pct = 23;
    set_max_length(200);
    random_traffic(SEG_BYTES);
    set_max_length(lpfp_pkg::HDR_BYTES + 1);
    random_traffic(SEG_BYTES);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_max_length(2097151);
    hold_trigger <= ~hold_trigger;
    random_traffic(SEG_BYTES);
    set_max_length(int'(lpfp_pkg::MAX_LEN_RESET));
    random_traffic(SEG_BYTES);

    settle();
    $display("sent %0d stream bytes under %0d length limits, long output stall included",
             bytes_sent, n_settings);
    $display("checked %0d headers, %0d payload bytes, %0d length errors",
             n_headers, n_payload, n_errors);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
